// ===== design/keyframe_vector_interpolator_assert.svh =====
// Assertion macros shared by the keyframe interpolator modules.
// No dependencies.
`ifndef KEYFRAME_VECTOR_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_VECTOR_INTERPOLATOR_ASSERT_SVH
`define KVI_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define KVI_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== design/kvi_pkg.sv =====
// Shared types and constants for the keyframe interpolator.
// No dependencies.
`timescale 1ns / 1ps
package kvi_pkg;
  localparam int MAX_KEYS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_INTERP   = 2'd0,
    KIND_CLAMP    = 2'd1,
    KIND_DEFAULT  = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] key_time;
    logic [31:0] key_x;
    logic [31:0] key_y;
    logic [31:0] key_z;
    logic [31:0] query_time;
  } cmd_t;
endpackage

// ===== design/kvi_front.sv =====
// Front end: accepts input words, drops skipped loads and idle codes.
// Pushes commands into a two-entry queue. Depends on kvi_pkg.
`timescale 1ns / 1ps
module kvi_front import kvi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_key_time,
  input  logic [31:0] in_key_x,
  input  logic [31:0] in_key_y,
  input  logic [31:0] in_key_z,
  input  logic        in_key_has_data,
  input  logic [31:0] in_query_time,
  output logic        q_valid,
  input  logic        q_ready,
  output cmd_t        q_cmd
);
  cmd_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop, keep;
  cmd_t c;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rp_r];
  assign pop = q_valid && q_ready;
  always_comb begin
    keep = (action_t'(in_action) == ACT_CLEAR) || (action_t'(in_action) == ACT_QUERY) ||
           ((action_t'(in_action) == ACT_LOAD) && in_key_has_data);
    c.action = action_t'(in_action);
    c.key_time = in_key_time;
    c.key_x = in_key_x;
    c.key_y = in_key_y;
    c.key_z = in_key_z;
    c.query_time = in_query_time;
  end
  assign push = in_valid && in_ready && keep;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  `include "keyframe_vector_interpolator_assert.svh"
  `KVI_ASSERT_IMPL(a_no_push_full, clk, rst_n, cnt_r == 2'd2, !push)
  `KVI_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_r != 2'd3)
  `KVI_ASSERT_NEXT(a_fill, clk, rst_n, push && !pop && cnt_r == 2'd0, cnt_r == 2'd1)
endmodule

// ===== design/kvi_back.sv =====
// Back end: key store, scan, serial divider and blend sequencer.
// Depends on kvi_pkg.
`timescale 1ns / 1ps
module kvi_back import kvi_pkg::*; #(
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  input  logic [31:0] default_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [1:0]  out_result_kind
);
  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int NW = 32 + FRAC_BITS;
  localparam int DC = $clog2(NW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_CHK0, S_RDL, S_CHKL, S_SCAN, S_SCANW, S_RDP, S_RDI,
    S_DIV, S_MUL, S_SUM, S_OUT
  } state_t;

  logic [31:0] mt [MAX_KEYS];
  logic [31:0] mx [MAX_KEYS];
  logic [31:0] my [MAX_KEYS];
  logic [31:0] mz [MAX_KEYS];
  logic [31:0] rt, rx, ry, rz;
  logic [AW-1:0] ra;

  state_t st_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] idx_r;
  logic [31:0] t_r, tp_r;
  logic [31:0] px_r, py_r, pz_r;
  logic signed [32:0] dx_r, dy_r, dz_r;
  logic [NW-1:0] num_r, quo_r;
  logic [32:0] rem_r;
  logic [31:0] den_r;
  logic [DC-1:0] dcnt_r;
  logic signed [33+FRAC_BITS:0] p_r [3];
  logic [1:0] comp_r;
  logic [31:0] ox_r, oy_r, oz_r;
  logic [1:0] ok_r;
  logic [AW-1:0] last;
  logic [32:0] rem_sh;
  logic signed [FRAC_BITS+1:0] f_s;
  logic signed [32:0] dsel;
  logic signed [33+FRAC_BITS:0] prod;
  logic [31:0] q_comp [3];

  assign last = AW'(cnt_r - CW'(1));
  assign q_ready = (st_r == S_IDLE) && !out_valid;
  assign out_x = ox_r;
  assign out_y = oy_r;
  assign out_z = oz_r;
  assign out_result_kind = ok_r;

  always_ff @(posedge clk) begin
    if (q_valid && q_ready && q_cmd.action == ACT_LOAD && cnt_r < CW'(MAX_KEYS)) begin
      mt[cnt_r[AW-1:0]] <= q_cmd.key_time;
      mx[cnt_r[AW-1:0]] <= q_cmd.key_x;
      my[cnt_r[AW-1:0]] <= q_cmd.key_y;
      mz[cnt_r[AW-1:0]] <= q_cmd.key_z;
    end
    rt <= mt[ra];
    rx <= mx[ra];
    ry <= my[ra];
    rz <= mz[ra];
  end

  always_comb begin
    rem_sh = {rem_r[31:0], num_r[NW-1]};
    f_s = {2'b00, quo_r[FRAC_BITS-1:0]};
    case (comp_r)
      2'd0: dsel = dx_r;
      2'd1: dsel = dy_r;
      default: dsel = dz_r;
    endcase
    prod = (33+FRAC_BITS+1)'(dsel * f_s);
    for (int k = 0; k < 3; k++) q_comp[k] = 32'(p_r[k] >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      out_valid <= 1'b0;
      ra <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid && q_ready) begin
          t_r <= q_cmd.query_time;
          case (q_cmd.action)
            ACT_CLEAR: cnt_r <= '0;
            ACT_LOAD: begin
              if (cnt_r < CW'(MAX_KEYS)) cnt_r <= cnt_r + CW'(1);
              else begin
                ox_r <= '0; oy_r <= '0; oz_r <= '0;
                ok_r <= KIND_OVERFLOW;
                out_valid <= 1'b1;
              end
            end
            ACT_QUERY: begin
              if (cnt_r == '0) begin
                ox_r <= default_value; oy_r <= default_value; oz_r <= default_value;
                ok_r <= KIND_DEFAULT;
                out_valid <= 1'b1;
              end else begin
                ra <= '0;
                st_r <= S_RD0;
              end
            end
            default: ;
          endcase
        end
        S_RD0: st_r <= S_CHK0;
        S_CHK0: begin
          if (cnt_r == CW'(1) || t_r <= rt) begin
            ox_r <= rx; oy_r <= ry; oz_r <= rz;
            ok_r <= KIND_CLAMP;
            st_r <= S_OUT;
          end else begin
            ra <= last;
            st_r <= S_RDL;
          end
        end
        S_RDL: st_r <= S_CHKL;
        S_CHKL: begin
          if (t_r >= rt) begin
            ox_r <= rx; oy_r <= ry; oz_r <= rz;
            ok_r <= KIND_CLAMP;
            st_r <= S_OUT;
          end else begin
            ra <= AW'(1);
            idx_r <= AW'(1);
            st_r <= S_SCANW;
          end
        end
        S_SCANW: st_r <= S_SCAN;
        S_SCAN: begin
          if (t_r < rt || idx_r == last) begin
            ra <= idx_r - AW'(1);
            st_r <= S_RDP;
          end else begin
            idx_r <= idx_r + AW'(1);
            ra <= idx_r + AW'(1);
            st_r <= S_SCANW;
          end
        end
        S_RDP: begin
          ra <= idx_r;
          st_r <= S_RDI;
        end
        S_RDI: begin
          tp_r <= rt;
          px_r <= rx; py_r <= ry; pz_r <= rz;
          st_r <= S_SUM;
          comp_r <= 2'd3;
        end
        S_SUM: begin
          if (comp_r == 2'd3) begin
            dx_r <= $signed({rx[31], rx}) - $signed({px_r[31], px_r});
            dy_r <= $signed({ry[31], ry}) - $signed({py_r[31], py_r});
            dz_r <= $signed({rz[31], rz}) - $signed({pz_r[31], pz_r});
            den_r <= rt - tp_r;
            num_r <= {t_r - tp_r, {FRAC_BITS{1'b0}}};
            rem_r <= '0;
            dcnt_r <= DC'(NW);
            st_r <= S_DIV;
          end else begin
            ox_r <= px_r + q_comp[0];
            oy_r <= py_r + q_comp[1];
            oz_r <= pz_r + q_comp[2];
            ok_r <= KIND_INTERP;
            st_r <= S_OUT;
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, den_r}) begin
            rem_r <= rem_sh - {1'b0, den_r};
            quo_r <= {quo_r[NW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[NW-2:0], 1'b0};
          end
          num_r <= {num_r[NW-2:0], 1'b0};
          dcnt_r <= dcnt_r - DC'(1);
          if (dcnt_r == DC'(1)) begin
            comp_r <= 2'd0;
            st_r <= S_MUL;
          end
        end
        S_MUL: begin
          p_r[comp_r] <= prod;
          if (comp_r == 2'd2) begin
            comp_r <= 2'd0;
            st_r <= S_SUM;
          end else comp_r <= comp_r + 2'd1;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `include "keyframe_vector_interpolator_assert.svh"
  `KVI_ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= CW'(MAX_KEYS))
  `KVI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `KVI_ASSERT_IMPL(a_busy, clk, rst_n, st_r != S_IDLE, !q_ready)
endmodule

// ===== design/keyframe_vector_interpolator.sv =====
// Keyframe vector interpolator top level: front queue, back sequencer, config.
// Default and overflow results come from the idle state; clamping tests key 0 and
// the last key; interpolation scans, divides, multiplies, sums. Loads and clears
// retire one per cycle if no result waits; a result stalls the back until taken.
// Synchronous active-low reset empties the store and sets default_value to 0.
// Depends on kvi_pkg, kvi_front, kvi_back.
`timescale 1ns / 1ps
module keyframe_vector_interpolator import kvi_pkg::*; #(
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_default_value,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_key_time,
  input  logic [31:0] in_key_x,
  input  logic [31:0] in_key_y,
  input  logic [31:0] in_key_z,
  input  logic        in_key_has_data,
  input  logic [31:0] in_query_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [1:0]  out_result_kind
);
  logic [31:0] default_r;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) default_r <= '0;
    else if (cfg_valid) default_r <= cfg_default_value;
  end

  kvi_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_key_time, .in_key_x,
    .in_key_y, .in_key_z, .in_key_has_data, .in_query_time,
    .q_valid, .q_ready, .q_cmd
  );

  kvi_back #(.MAX_KEYS(MAX_KEYS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .default_value(default_r),
    .out_valid, .out_ready, .out_x, .out_y, .out_z, .out_result_kind
  );
endmodule

// ===== sim/keyframe_vector_interpolator_tb.sv =====
// Testbench for keyframe_vector_interpolator: keyframe loads, clears, queries and overflow,
// checked word by word against a behavioral predictor under random idling.
// Depends on kvi_pkg and the keyframe_vector_interpolator RTL.
`timescale 1ns / 1ps
module keyframe_vector_interpolator_tb;
  import kvi_pkg::*;

  localparam int NKEYS = MAX_KEYS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int SETTLE = 400;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    kind_t       kind;
  } vec_word_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [31:0] cfg_default_value;
  logic in_valid, in_ready;
  logic [1:0] in_action;
  logic [31:0] in_key_time, in_key_x, in_key_y, in_key_z, in_query_time;
  logic in_key_has_data;
  logic out_valid, out_ready;
  logic [31:0] out_x, out_y, out_z;
  logic [1:0] out_result_kind;

  keyframe_vector_interpolator u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_default_value(cfg_default_value),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_key_time(in_key_time), .in_key_x(in_key_x), .in_key_y(in_key_y),
    .in_key_z(in_key_z), .in_key_has_data(in_key_has_data),
    .in_query_time(in_query_time),
    .out_valid(out_valid), .out_ready(out_ready), .out_x(out_x), .out_y(out_y),
    .out_z(out_z), .out_result_kind(out_result_kind)
  );

  logic [31:0] mdl_time [NKEYS];
  logic [31:0] mdl_x [NKEYS];
  logic [31:0] mdl_y [NKEYS];
  logic [31:0] mdl_z [NKEYS];
  int mdl_count;
  logic [31:0] mdl_default;
  vec_word_t pending_words[$];
  int errors;
  int send_idle_pct, recv_stall_pct;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("** keyframe_vector_interpolator: FAILED **");
    $finish;
  end

  function automatic logic [31:0] blend_toward(logic [31:0] a, logic [31:0] b,
                                               longint unsigned f);
    longint va, d, p, q;
    va = longint'(signed'(a));
    d = longint'(signed'(b)) - va;
    p = d * longint'(f);
    q = p >>> FB;
    return 32'(va + q);
  endfunction

  task automatic predict_item(logic [1:0] act, logic [31:0] kt, logic [31:0] kx,
                              logic [31:0] ky, logic [31:0] kz, logic hd, logic [31:0] qt);
    vec_word_t w;
    int i, last;
    longint unsigned num, den, f;
    case (act)
      ACT_CLEAR: mdl_count = 0;
      ACT_LOAD: begin
        if (hd) begin
          if (mdl_count >= NKEYS) begin
            w = '{32'd0, 32'd0, 32'd0, KIND_OVERFLOW};
            pending_words.insert(pending_words.size(), w);
          end else begin
            mdl_time[mdl_count] = kt;
            mdl_x[mdl_count] = kx;
            mdl_y[mdl_count] = ky;
            mdl_z[mdl_count] = kz;
            mdl_count++;
          end
        end
      end
      ACT_QUERY: begin
        last = mdl_count - 1;
        if (mdl_count == 0) begin
          w = '{mdl_default, mdl_default, mdl_default, KIND_DEFAULT};
        end else if (mdl_count == 1 || qt <= mdl_time[0]) begin
          w = '{mdl_x[0], mdl_y[0], mdl_z[0], KIND_CLAMP};
        end else if (qt >= mdl_time[last]) begin
          w = '{mdl_x[last], mdl_y[last], mdl_z[last], KIND_CLAMP};
        end else begin
          i = last;
          for (int k = 1; k < mdl_count; k++) begin
            if (qt < mdl_time[k]) begin
              i = k;
              break;
            end
          end
          num = longint'(32'(qt - mdl_time[i-1])) << FB;
          den = longint'(32'(mdl_time[i] - mdl_time[i-1]));
          f = (den != 0) ? num / den : 0;
          w = '{blend_toward(mdl_x[i-1], mdl_x[i], f), blend_toward(mdl_y[i-1], mdl_y[i], f),
                blend_toward(mdl_z[i-1], mdl_z[i], f), KIND_INTERP};
        end
        pending_words.insert(pending_words.size(), w);
      end
      default: ;
    endcase
  endtask

  task automatic send_item(logic [1:0] act, logic [31:0] kt, logic [31:0] kx,
                           logic [31:0] ky, logic [31:0] kz, logic hd, logic [31:0] qt);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1;
    in_action = act;
    in_key_time = kt;
    in_key_x = kx;
    in_key_y = ky;
    in_key_z = kz;
    in_key_has_data = hd;
    in_query_time = qt;
    predict_item(act, kt, kx, ky, kz, hd, qt);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain_and_config(logic [31:0] dv);
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1;
    cfg_default_value <= dv;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    mdl_default = dv;
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    vec_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word x=%h y=%h z=%h kind=%0d", $time, out_x, out_y,
                 out_z, out_result_kind);
        errors++;
      end else begin
        w = pending_words.pop_front();
        if (out_x !== w.x || out_y !== w.y || out_z !== w.z || out_result_kind !== w.kind) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h kind=%0d actual x=%h y=%h z=%h kind=%0d",
                   $time, w.x, w.y, w.z, w.kind, out_x, out_y, out_z, out_result_kind);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(ACT_QUERY, 0, 0, 0, 0, 1'b0, 32'hFFFF_FFFF);
    send_item(ACT_LOAD, 32'h10, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 0);
    send_item(ACT_NONE, 32'hFFFF_FFFF, '1, '1, '1, 1'b1, '1);
    send_item(ACT_QUERY, 0, 0, 0, 0, 1'b0, 5);
    send_item(ACT_LOAD, 32'h1_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b1, 0);
    send_item(ACT_QUERY, 0, 0, 0, 0, 1'b0, 0);
    send_item(ACT_QUERY, 0, 0, 0, 0, 1'b0, 32'hFFFF_FFFF);
    send_item(ACT_LOAD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b1, 0);
    send_item(ACT_QUERY, 0, 0, 0, 0, 1'b0, 32'h1_0000);
    send_item(ACT_QUERY, 0, 0, 0, 0, 1'b0, 32'h1_0001);
    send_item(ACT_QUERY, 0, 0, 0, 0, 1'b0, 32'hFFFF_FFFE);
    send_item(ACT_QUERY, 0, 0, 0, 0, 1'b0, 32'h8000_0000);
    send_item(ACT_LOAD, 32'h10, 32'h55, 32'h66, 32'h77, 1'b1, 0);
    send_item(ACT_QUERY, 0, 0, 0, 0, 1'b0, 32'h2000_0000);
    send_item(ACT_CLEAR, 0, 0, 0, 0, 1'b0, 0);
    send_item(ACT_QUERY, 0, 0, 0, 0, 1'b0, 32'h40);
    for (int k = 0; k <= NKEYS; k++)
      send_item(ACT_LOAD, k * 32'h100, $urandom, $urandom, $urandom, 1'b1, 0);
    send_item(ACT_QUERY, 0, 0, 0, 0, 1'b0, 32'h1080);
  endtask

  task automatic test_random(int n);
    logic [31:0] t;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: send_item(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'($urandom),
                     $urandom);
        1: send_item(2'($urandom), $urandom, $urandom, $urandom, $urandom, 1'($urandom),
                     $urandom);
        2, 3: begin
          if (mdl_count == 0) t = $urandom_range(1000);
          else t = mdl_time[mdl_count-1] + $urandom_range(5000);
          if ($urandom_range(20) == 0) t = $urandom;
          send_item(ACT_LOAD, t, $urandom, $urandom, $urandom, $urandom_range(9) != 0,
                    $urandom);
          if (mdl_count > 8 && $urandom_range(3) == 0)
            send_item(ACT_CLEAR, 0, 0, 0, 0, 1'b0, 0);
        end
        default: begin
          if (mdl_count > 0 && $urandom_range(7) != 0)
            t = mdl_time[0] + $urandom_range(mdl_time[mdl_count-1] - mdl_time[0] + 10);
          else t = $urandom;
          send_item(ACT_QUERY, $urandom, $urandom, $urandom, $urandom, 1'($urandom), t);
        end
      endcase
    end
  endtask

  initial begin
    errors = 0;
    rst_n = 0;
    cfg_valid = 0;
    cfg_default_value = 0;
    in_valid = 0;
    in_action = 0;
    in_key_time = 0;
    in_key_x = 0;
    in_key_y = 0;
    in_key_z = 0;
    in_key_has_data = 0;
    in_query_time = 0;
    out_ready = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mdl_count = 0;
    mdl_default = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    drain_and_config(32'h7FFF_FFFF);
    send_item(ACT_CLEAR, 0, 0, 0, 0, 1'b0, 0);
    send_item(ACT_QUERY, 0, 0, 0, 0, 1'b0, 1);
    drain_and_config(32'h8000_0000);
    send_item(ACT_QUERY, 0, 0, 0, 0, 1'b0, 1);
    test_random(300);
    drain_and_config($urandom);
    send_idle_pct = 66;
    test_random(300);
    drain_and_config(32'h0001_0000);
    send_idle_pct = 0;
    recv_stall_pct = 66;
    test_random(300);
    drain_and_config(32'h0);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    test_random(300);
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) $display("** keyframe_vector_interpolator: PASSED **");
    else $display("** keyframe_vector_interpolator: FAILED **");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/kvi_pkg.sv
design/kvi_front.sv
design/kvi_back.sv
design/keyframe_vector_interpolator.sv
sim/keyframe_vector_interpolator_tb.sv
